[rtl/csort_pkg.sv]
// shared types and constants of the cocktail shaker sorter
package csort_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic               drop;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_beat_t;

endpackage

[rtl/csort_if.sv]
// valid/ready channels of the cocktail shaker sorter
interface csort_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink (input valid, input value, input last_item, output ready);
endinterface

interface csort_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic               last_out;
  logic               overflowed;

  modport source (output valid, output sorted_value, output last_out, output overflowed,
                  input ready);
  modport sink (input valid, input sorted_value, input last_out, input overflowed,
                output ready);
endinterface

[rtl/csort_front.sv]
// input side: accepts beats and marks those beyond capacity as dropped
module csort_front import csort_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  csort_in_if.sink in_i,
  output q_beat_t push_o,
  input  logic    push_ready_i
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full;
  logic            fire;

  assign full        = (cnt_q == CntW'(MAX_ITEMS));
  assign in_i.ready  = push_ready_i;
  assign fire        = in_i.valid & push_ready_i;

  assign push_o.valid       = in_i.valid;
  assign push_o.entry.value = in_i.value;
  assign push_o.entry.last  = in_i.last_item;
  assign push_o.entry.drop  = full;

  always_comb begin
    cnt_d = cnt_q;
    if (fire) begin
      if (in_i.last_item) begin
        cnt_d = '0;
      end else if (!full) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/csort_fifo.sv]
// short queue between the input side and the sort engine
module csort_fifo import csort_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_beat_t push_i,
  output logic    push_ready_o,
  output q_beat_t pop_o,
  input  logic    pop_ready_i
);

  entry_t            buf_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, rptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_o.valid  = (cnt_q != '0);
  assign pop_o.entry  = buf_q[rptr_q];
  assign do_push      = push_i.valid & push_ready_o;
  assign do_pop       = pop_o.valid & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

[rtl/csort_back.sv]
// sort engine: loads the store, runs shaker passes, streams the result
module csort_back import csort_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_beat_t pop_i,
  output logic    pop_ready_o,
  csort_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [10:0] {
    S_LOAD   = 11'b000_0000_0001,
    S_FPRIME = 11'b000_0000_0010,
    S_FLOAD  = 11'b000_0000_0100,
    S_FWD    = 11'b000_0000_1000,
    S_FEND   = 11'b000_0001_0000,
    S_BPRIME = 11'b000_0010_0000,
    S_BLOAD  = 11'b000_0100_0000,
    S_BWD    = 11'b000_1000_0000,
    S_BEND   = 11'b001_0000_0000,
    S_ERD    = 11'b010_0000_0000,
    S_EOUT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0] mem [MAX_ITEMS];
  logic signed [31:0] rdata_q;
  logic [IdxW-1:0]    raddr, waddr;
  logic signed [31:0] wdata;
  logic               we;

  logic [CntW-1:0]    cnt_q, cnt_d, n_last;
  logic               ovf_q, ovf_d;
  logic [IdxW-1:0]    lo_q, lo_d, hi_q, hi_d, idx_q, idx_d, k_q, k_d;
  logic signed [31:0] carry_q, carry_d;
  logic               swap_q, swap_d;

  logic               out_vq, out_vd, out_load, out_last;
  logic signed [31:0] out_val_q;
  logic               out_last_q, out_ovf_q;

  assign out_o.valid        = out_vq;
  assign out_o.sorted_value = out_val_q;
  assign out_o.last_out     = out_last_q;
  assign out_o.overflowed   = out_ovf_q;

  assign pop_ready_o = (state_q == S_LOAD);
  assign n_last      = pop_i.entry.drop ? cnt_q : cnt_q + CntW'(1);
  assign out_last    = (CntW'(k_q) + CntW'(1) == cnt_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    idx_d    = idx_q;
    k_d      = k_q;
    carry_d  = carry_q;
    swap_d   = swap_q;
    raddr    = k_q;
    waddr    = idx_q;
    wdata    = carry_q;
    we       = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_LOAD: begin
        k_d = '0;
        if (pop_i.valid) begin
          if (pop_i.entry.drop) begin
            ovf_d = 1'b1;
          end else begin
            we    = 1'b1;
            waddr = cnt_q[IdxW-1:0];
            wdata = pop_i.entry.value;
            cnt_d = cnt_q + CntW'(1);
          end
          if (pop_i.entry.last) begin
            lo_d = '0;
            hi_d = IdxW'(n_last - CntW'(1));
            if (n_last < CntW'(2)) begin
              state_d = S_ERD;
            end else begin
              state_d = S_FPRIME;
            end
          end
        end
      end
      S_FPRIME: begin
        raddr   = lo_q;
        swap_d  = 1'b0;
        state_d = S_FLOAD;
      end
      S_FLOAD: begin
        carry_d = rdata_q;
        raddr   = lo_q + IdxW'(1);
        idx_d   = lo_q;
        state_d = S_FWD;
      end
      S_FWD: begin
        we    = 1'b1;
        waddr = idx_q;
        if (carry_q > rdata_q) begin
          wdata  = rdata_q;
          swap_d = 1'b1;
        end else begin
          wdata   = carry_q;
          carry_d = rdata_q;
        end
        raddr = idx_q + IdxW'(2);
        idx_d = idx_q + IdxW'(1);
        if (idx_q + IdxW'(1) == hi_q) begin
          state_d = S_FEND;
        end
      end
      S_FEND: begin
        we    = 1'b1;
        waddr = hi_q;
        wdata = carry_q;
        hi_d  = hi_q - IdxW'(1);
        if (!swap_q || lo_q >= hi_q - IdxW'(1)) begin
          state_d = S_ERD;
        end else begin
          state_d = S_BPRIME;
        end
      end
      S_BPRIME: begin
        raddr   = hi_q;
        swap_d  = 1'b0;
        state_d = S_BLOAD;
      end
      S_BLOAD: begin
        carry_d = rdata_q;
        raddr   = hi_q - IdxW'(1);
        idx_d   = hi_q;
        state_d = S_BWD;
      end
      S_BWD: begin
        we    = 1'b1;
        waddr = idx_q;
        if (rdata_q > carry_q) begin
          wdata  = rdata_q;
          swap_d = 1'b1;
        end else begin
          wdata   = carry_q;
          carry_d = rdata_q;
        end
        raddr = idx_q - IdxW'(2);
        idx_d = idx_q - IdxW'(1);
        if (idx_q - IdxW'(1) == lo_q) begin
          state_d = S_BEND;
        end
      end
      S_BEND: begin
        we    = 1'b1;
        waddr = lo_q;
        wdata = carry_q;
        lo_d  = lo_q + IdxW'(1);
        if (!swap_q || lo_q + IdxW'(1) >= hi_q) begin
          state_d = S_ERD;
        end else begin
          state_d = S_FPRIME;
        end
      end
      S_ERD: begin
        raddr   = k_q;
        state_d = S_EOUT;
      end
      S_EOUT: begin
        raddr = k_q;
        if (!out_vq || out_o.ready) begin
          out_load = 1'b1;
          raddr    = k_q + IdxW'(1);
          k_d      = k_q + IdxW'(1);
          if (out_last) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_comb begin
    out_vd = out_vq;
    if (out_load) begin
      out_vd = 1'b1;
    end else if (out_o.ready) begin
      out_vd = 1'b0;
    end
  end

  // element store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    idx_q   <= idx_d;
    if (out_load) begin
      out_val_q  <= rdata_q;
      out_last_q <= out_last;
      out_ovf_q  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      k_q     <= '0;
      swap_q  <= 1'b0;
      out_vq  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      k_q     <= k_d;
      swap_q  <= swap_d;
      out_vq  <= out_vd;
    end
  end

endmodule

[rtl/cocktail_shaker_sorter.sv]
// top level of the cocktail shaker sorter
// loading takes a beat whenever the queue holds one; a list of n values is emitted at up to
// one beat per cycle while the receiver is ready; each pass primes a read, loads the first
// value, writes back one value per compared pair and stores the carry at the window end;
// S_ERD reads the first result and S_EOUT stages it; the next list loads once the last beat
// is staged; reset clears control state but idx_q; the undefined store needs no clearing pass
module cocktail_shaker_sorter import csort_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  csort_in_if.sink      in_i,
  csort_out_if.source   out_o
);

  q_beat_t push, pop;
  logic    push_ready, pop_ready;

  csort_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  csort_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_o        (pop),
    .pop_ready_i  (pop_ready)
  );

  csort_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready
      |=> out_o.valid && $stable(out_o.sorted_value) && $stable(out_o.last_out)
          && $stable(out_o.overflowed))
    else $error("result beat changes while stalled");

  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last_out
      |=> !out_o.valid || (out_o.overflowed == $past(out_o.overflowed)))
    else $error("overflow flag changes within a list");

  a_pop_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop.valid && pop_ready && pop.entry.last |=> !pop_ready)
    else $error("queue drained while the store is busy");

endmodule

[test/cocktail_shaker_sorter_tb.sv]
// testbench of the cocktail shaker sorter: directed lists, then random lists checked beat by beat
`timescale 1ns / 1ps

module cocktail_shaker_sorter_tb;

  localparam int MaxItems = 64;

  typedef struct {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflowed;
  } sorted_beat_t;

  typedef struct {
    logic signed [31:0] value;
    bit                 last;
    bit                 typed;
    logic signed [31:0] want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  csort_in_if  in_if ();
  csort_out_if out_if ();

  cocktail_shaker_sorter #(
    .MAX_ITEMS(MaxItems)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #4 clk_i = ~clk_i;

  logic signed [31:0] list_store [MaxItems];
  int                 list_len;
  bit                 list_dropped;
  sorted_beat_t       pending_sorted [$];
  int                 mismatch_cnt;
  int                 send_idle_pct;
  int                 recv_stall_pct;

  // single-value lists carry their expected beat in the table
  stim_row_t dir_rows [24] = '{
    '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000},
    '{32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff},
    '{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000},
    '{32'shffff_ffff, 1'b1, 1'b1, 32'shffff_ffff},
    '{32'sh7fff_ffff, 1'b0, 1'b0, 32'sh0},
    '{32'shffff_ffff, 1'b0, 1'b0, 32'sh0},
    '{32'sh8000_0000, 1'b0, 1'b0, 32'sh0},
    '{32'sh0000_0000, 1'b0, 1'b0, 32'sh0},
    '{32'sh0000_0001, 1'b1, 1'b0, 32'sh0},
    '{32'sh0000_0005, 1'b0, 1'b0, 32'sh0},
    '{32'sh0000_0005, 1'b0, 1'b0, 32'sh0},
    '{-32'sd5,        1'b0, 1'b0, 32'sh0},
    '{32'sh0000_0005, 1'b1, 1'b0, 32'sh0},
    '{-32'sd3,        1'b0, 1'b0, 32'sh0},
    '{-32'sd2,        1'b0, 1'b0, 32'sh0},
    '{-32'sd1,        1'b1, 1'b0, 32'sh0},
    '{32'sd40,        1'b0, 1'b0, 32'sh0},
    '{32'sd30,        1'b0, 1'b0, 32'sh0},
    '{32'sd20,        1'b0, 1'b0, 32'sh0},
    '{32'sd10,        1'b1, 1'b0, 32'sh0},
    '{32'sd1,         1'b0, 1'b0, 32'sh0},
    '{32'sd0,         1'b1, 1'b0, 32'sh0},
    '{32'sh5555_5555, 1'b1, 1'b1, 32'sh5555_5555},
    '{32'shaaaa_aaaa, 1'b1, 1'b1, 32'shaaaa_aaaa}
  };

  function automatic void shaker_sort_list(int n);
    int                 lo;
    int                 hi;
    int                 i;
    bit                 swapped;
    logic signed [31:0] t;
    if (n < 2) return;
    lo = 0;
    hi = n - 1;
    while (1) begin
      swapped = 0;
      for (i = lo; i < hi; i++) begin
        if (list_store[i] > list_store[i + 1]) begin
          t = list_store[i];
          list_store[i] = list_store[i + 1];
          list_store[i + 1] = t;
          swapped = 1;
        end
      end
      if (!swapped) break;
      hi--;
      if (lo >= hi) break;
      swapped = 0;
      for (i = hi; i > lo; i--) begin
        if (list_store[i - 1] > list_store[i]) begin
          t = list_store[i - 1];
          list_store[i - 1] = list_store[i];
          list_store[i] = t;
          swapped = 1;
        end
      end
      lo++;
      if (!swapped || lo >= hi) break;
    end
  endfunction

  function automatic void load_and_sort(logic signed [31:0] value, bit last);
    sorted_beat_t b;
    int           k;
    if (list_len < MaxItems) begin
      list_store[list_len] = value;
      list_len++;
    end else begin
      list_dropped = 1;
    end
    if (!last) return;
    shaker_sort_list(list_len);
    for (k = 0; k < list_len; k++) begin
      b.sorted_value = list_store[k];
      b.last_out     = (k == list_len - 1);
      b.overflowed   = list_dropped;
      pending_sorted.push_back(b);
    end
    list_len     = 0;
    list_dropped = 0;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_list_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 24);
    if (r < 95) return $urandom_range(25, MaxItems - 1);
    if (r < 97) return MaxItems;
    return $urandom_range(MaxItems + 1, MaxItems + 6);
  endfunction

  // starts and ends just after a falling edge
  task automatic send_beat(logic signed [31:0] value, bit last, bit typed,
                           logic signed [31:0] want);
    sorted_beat_t b;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.value     <= value;
    in_if.last_item <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    load_and_sort(value, last);
    if (typed) begin
      void'(pending_sorted.pop_back());
      b.sorted_value = want;
      b.last_out     = 1'b1;
      b.overflowed   = 1'b0;
      pending_sorted.push_back(b);
    end
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    sorted_beat_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_sorted.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected beat, expected none, got %0d/%0b/%0b", $time,
                 out_if.sorted_value, out_if.last_out, out_if.overflowed);
      end else begin
        want = pending_sorted.pop_front();
        if (out_if.sorted_value !== want.sorted_value || out_if.last_out !== want.last_out ||
            out_if.overflowed !== want.overflowed) begin
          mismatch_cnt++;
          $display("%0t: mismatch, expected %0d/%0b/%0b, got %0d/%0b/%0b", $time,
                   want.sorted_value, want.last_out, want.overflowed,
                   out_if.sorted_value, out_if.last_out, out_if.overflowed);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int phase;
    int phase_items;
    int len;
    int k;
    in_if.valid     = 1'b0;
    in_if.value     = '0;
    in_if.last_item = 1'b0;
    rst_ni          = 1'b0;
    list_len        = 0;
    list_dropped    = 0;
    mismatch_cnt    = 0;
    send_idle_pct   = 7;
    recv_stall_pct  = 58;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    end

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 7 : (phase == 1) ? 58 : 0;
      recv_stall_pct = (phase == 0) ? 58 : (phase == 1) ? 7 : 0;
      phase_items    = 0;
      while (phase_items < 120) begin
        // each phase opens with a full or overflowing list
        if (phase_items == 0) len = (phase == 0) ? MaxItems + 1 : (phase == 1) ? MaxItems : 70;
        else len = rand_list_len();
        for (k = 0; k < len; k++) send_beat(rand_value(), k == len - 1, 1'b0, 32'sh0);
        phase_items += len;
      end
      // hold off until all sorted beats have drained
      in_if.valid <= 1'b0;
      do @(negedge clk_i); while (pending_sorted.size() != 0);
    end

    in_if.valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
